// ===== hw/rtl/hac_pkg.sv =====
// hac_pkg: shared constants, types and the arctangent step table of the
// hall axis conditioner. No dependencies; used by every module of the block.
`default_nettype none

package hac_pkg;

  localparam int LANES        = 4;
  localparam int FIELD_BITS   = 12;
  localparam int ANGLE_BITS   = 15;
  localparam int LIMIT_BITS   = 8;
  localparam int AXIS_BITS    = 10;
  localparam int CFG_IDX_BITS = 2;
  localparam int MASK_BITS    = LANES;

  localparam int UNITS_45          = 2880;
  localparam int UNITS_90          = 5760;
  localparam int UNITS_180         = 11520;
  localparam int FULL_SCALE        = 1023;
  localparam int AVG_WINDOW        = 15;
  localparam int COUNT_MAX         = 255;
  localparam int MIN_ANGLE_RESET   = -10432;
  localparam int MAX_ANGLE_RESET   = -4160;
  localparam int STUCK_LIMIT_RESET = 50;

  localparam int CORDIC_STEPS = 56;
  localparam int STEP_BITS    = 6;
  localparam int XY_FRAC      = 48;
  localparam int Z_FRAC       = 44;

  localparam int NUM_BITS = 27;
  localparam int DEN_BITS = 16;
  localparam int Q_BITS   = 10;
  localparam int QIDX_BITS = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_ANGLE   = 2'd0,
    CFG_MAX_ANGLE   = 2'd1,
    CFG_STUCK_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] min_angle;
    logic signed [ANGLE_BITS-1:0] max_angle;
  } win_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_ANGLE,
    LN_SCALE_SET,
    LN_SCALE,
    LN_AVG_SET,
    LN_AVG
  } lane_state_t;

  typedef enum logic {
    TOP_IDLE,
    TOP_BUSY
  } top_state_t;

  typedef logic [63:0] arc_tab_t [CORDIC_STEPS];

  localparam logic [63:0] Q_ONE = 64'h4000_0000_0000_0000;

  // arctan(1/5) in q62
  function automatic logic [63:0] atan_inv5();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    p   = Q_ONE / 64'd5;
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      t = p / 64'(2 * k + 1);
      if (k % 2 == 1) sum = sum - t;
      else sum = sum + t;
      p = p / 64'd25;
    end
    return sum;
  endfunction

  // arctan(1/239) in q62
  function automatic logic [63:0] atan_inv239();
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    p   = Q_ONE / 64'd239;
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      t = p / 64'(2 * k + 1);
      if (k % 2 == 1) sum = sum - t;
      else sum = sum + t;
      p = p / 64'd57121;
    end
    return sum;
  endfunction

  // arctan(2^-i) in q62, i >= 1
  function automatic logic [63:0] atan_pow2(input int unsigned i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    p   = Q_ONE >> i;
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      t = p / 64'(2 * k + 1);
      if (k % 2 == 1) sum = sum - t;
      else sum = sum + t;
      p = (2 * i < 63) ? (p >> (2 * i)) : 64'd0;
    end
    return sum;
  endfunction

  // pi/4 in q62
  localparam logic [63:0] QP_45 = (atan_inv5() << 2) - atan_inv239();

  // step angles in 1/64 degree with Z_FRAC fraction bits
  function automatic arc_tab_t build_arc_tab();
    arc_tab_t     tab;
    logic [127:0] w;
    logic [63:0]  a;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      a = (i == 0) ? QP_45 : atan_pow2(i);
      w = ({64'd0, a} * 128'(UNITS_45)) << Z_FRAC;
      w = (w + 128'(QP_45 >> 1)) / 128'(QP_45);
      tab[i] = w[63:0];
    end
    return tab;
  endfunction

  localparam arc_tab_t ARC_TAB = build_arc_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/hall_axis_conditioner.sv =====
// hall_axis_conditioner: top level, four sensor lanes side by side, stuck
// sensor tracking and the merging output register. Depends on hac_pkg and hac_lane.
//
// Use: an item on the input channel (in_valid / in_stall) carries the X and Y
// field counts of four sensors. Each lane forms the angle with a 56-step
// cordic unit, holds the last in-window angle, scales it to 0..1023 through a
// ten-step divider and averages the last 15 values with a second ten-step
// division. A lane takes longer when its scaling goes through the divider; the
// block waits for the slowest lane before it loads the result and raises
// out_valid. The next item is accepted in the cycle after the result is
// loaded at the earliest, so no item is taken before the last one is through.
// The result then sits in the output register while the next item is
// worked on. One result item leaves on the output channel (out_valid /
// out_stall) per input item; while out_stall is high the result holds and
// the lanes keep a finished result until the register frees up.
// Configuration (cfg_we, cfg_index, cfg_data) writes the window limits and
// the stuck limit; the user must write it only while the block is idle; the
// block does not enforce this. Reset (rst_n low, synchronous) restores the register
// defaults and hold angles, clears averages and stuck counters, drops out_valid.
`default_nettype none

module hall_axis_conditioner (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]    in_field_x_1,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]    in_field_y_1,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]    in_field_x_2,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]    in_field_y_2,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]    in_field_x_3,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]    in_field_y_3,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]    in_field_x_4,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]    in_field_y_4,
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic [hac_pkg::AXIS_BITS-1:0]                 out_axis_1,
  output logic [hac_pkg::AXIS_BITS-1:0]                 out_axis_2,
  output logic [hac_pkg::AXIS_BITS-1:0]                 out_axis_3,
  output logic [hac_pkg::AXIS_BITS-1:0]                 out_axis_4,
  output logic [hac_pkg::MASK_BITS-1:0]                 out_stuck_mask,
  input  wire logic                                     cfg_we,
  input  wire logic [hac_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  wire logic [hac_pkg::ANGLE_BITS-1:0]           cfg_data
);

  hac_pkg::top_state_t state_r, state_nxt;

  logic signed [hac_pkg::ANGLE_BITS-1:0] min_angle_r, max_angle_r;
  logic [hac_pkg::LIMIT_BITS-1:0]        stuck_limit_r;
  hac_pkg::win_t                         win;

  logic signed [hac_pkg::FIELD_BITS-1:0] fx [hac_pkg::LANES];
  logic signed [hac_pkg::FIELD_BITS-1:0] fy [hac_pkg::LANES];
  logic [hac_pkg::FIELD_BITS-1:0]        last_x_r [hac_pkg::LANES];
  logic [hac_pkg::FIELD_BITS-1:0]        last_x_nxt [hac_pkg::LANES];
  logic [hac_pkg::LIMIT_BITS-1:0]        cnt_r [hac_pkg::LANES];
  logic [hac_pkg::LIMIT_BITS-1:0]        cnt_nxt [hac_pkg::LANES];
  logic [hac_pkg::MASK_BITS-1:0]         mask_r, mask_nxt;
  logic                                  found;

  logic [hac_pkg::LANES-1:0]     lane_busy;
  logic [hac_pkg::AXIS_BITS-1:0] lane_axis [hac_pkg::LANES];
  logic [hac_pkg::AXIS_BITS-1:0] axis_out_r [hac_pkg::LANES];
  logic [hac_pkg::MASK_BITS-1:0] mask_out_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          accept, load;

  assign fx[0] = in_field_x_1;
  assign fy[0] = in_field_y_1;
  assign fx[1] = in_field_x_2;
  assign fy[1] = in_field_y_2;
  assign fx[2] = in_field_x_3;
  assign fy[2] = in_field_y_3;
  assign fx[3] = in_field_x_4;
  assign fy[3] = in_field_y_4;

  assign win.min_angle = min_angle_r;
  assign win.max_angle = max_angle_r;

  assign in_stall = (state_r == hac_pkg::TOP_BUSY);
  assign accept   = in_valid && !in_stall;

  for (genvar i = 0; i < hac_pkg::LANES; i++) begin : g_lane
    hac_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (accept),
      .field_x (fx[i]),
      .field_y (fy[i]),
      .win     (win),
      .busy    (lane_busy[i]),
      .axis    (lane_axis[i])
    );
  end

  // stuck tracking, lowest stuck lane wins
  always_comb begin
    found    = 1'b0;
    mask_nxt = mask_r;
    for (int i = 0; i < hac_pkg::LANES; i++) begin
      last_x_nxt[i] = last_x_r[i];
      cnt_nxt[i]    = cnt_r[i];
    end
    if (accept) begin
      mask_nxt = '0;
      for (int i = 0; i < hac_pkg::LANES; i++) begin
        if (unsigned'(fx[i]) != last_x_r[i] || fx[i] == '0) begin
          last_x_nxt[i] = unsigned'(fx[i]);
          cnt_nxt[i]    = '0;
        end else if (cnt_r[i] != hac_pkg::LIMIT_BITS'(hac_pkg::COUNT_MAX)) begin
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end
      end
      for (int i = 0; i < hac_pkg::LANES; i++) begin
        if (!found && cnt_nxt[i] >= stuck_limit_r) begin
          found       = 1'b1;
          mask_nxt[i] = 1'b1;
          cnt_nxt[i]  = '0;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      hac_pkg::TOP_IDLE: begin
        if (accept) state_nxt = hac_pkg::TOP_BUSY;
      end
      hac_pkg::TOP_BUSY: begin
        if (lane_busy == '0 && (!out_valid_r || !out_stall)) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = hac_pkg::TOP_IDLE;
        end
      end
      default: state_nxt = hac_pkg::TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= hac_pkg::TOP_IDLE;
      out_valid_r   <= 1'b0;
      min_angle_r   <= hac_pkg::ANGLE_BITS'(hac_pkg::MIN_ANGLE_RESET);
      max_angle_r   <= hac_pkg::ANGLE_BITS'(hac_pkg::MAX_ANGLE_RESET);
      stuck_limit_r <= hac_pkg::LIMIT_BITS'(hac_pkg::STUCK_LIMIT_RESET);
      mask_r        <= '0;
      for (int i = 0; i < hac_pkg::LANES; i++) begin
        last_x_r[i] <= '0;
        cnt_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
      for (int i = 0; i < hac_pkg::LANES; i++) begin
        last_x_r[i] <= last_x_nxt[i];
        cnt_r[i]    <= cnt_nxt[i];
      end
      if (cfg_we) begin
        case (hac_pkg::cfg_idx_t'(cfg_index))
          hac_pkg::CFG_MIN_ANGLE:   min_angle_r   <= signed'(cfg_data);
          hac_pkg::CFG_MAX_ANGLE:   max_angle_r   <= signed'(cfg_data);
          hac_pkg::CFG_STUCK_LIMIT: stuck_limit_r <= cfg_data[hac_pkg::LIMIT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mask_out_r <= mask_r;
      for (int i = 0; i < hac_pkg::LANES; i++) axis_out_r[i] <= lane_axis[i];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_axis_1     = axis_out_r[0];
  assign out_axis_2     = axis_out_r[1];
  assign out_axis_3     = axis_out_r[2];
  assign out_axis_4     = axis_out_r[3];
  assign out_stuck_mask = mask_out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hac_cordic.sv =====
// hac_cordic: iterative vectoring unit, one rotation per cycle, giving the
// rounded first-octant angle atan(s/l) in 1/64 degree. Depends on hac_pkg.
`default_nettype none

module hac_cordic (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [hac_pkg::FIELD_BITS-1:0]   s_mag,
  input  wire logic [hac_pkg::FIELD_BITS-1:0]   l_mag,
  output logic                                  done,
  output logic [hac_pkg::FIELD_BITS-1:0]        k_units
);

  localparam logic [hac_pkg::STEP_BITS-1:0] STEP_LAST =
    hac_pkg::STEP_BITS'(hac_pkg::CORDIC_STEPS - 1);
  localparam logic signed [63:0] Z_ROUND = 64'sd1 <<< (hac_pkg::Z_FRAC - 1);
  localparam int RND_BITS = 64 - hac_pkg::Z_FRAC;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [hac_pkg::STEP_BITS-1:0] step_r, step_nxt;
  logic signed [63:0]            x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [63:0]            dx, dy, arc, z_rnd;
  logic [RND_BITS-1:0]           rnd;

  always_comb begin
    dx       = y_r >>> step_r;
    dy       = x_r >>> step_r;
    arc      = signed'(hac_pkg::ARC_TAB[step_r]);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      x_nxt    = signed'(64'(l_mag) << hac_pkg::XY_FRAC);
      y_nxt    = signed'(64'(s_mag) << hac_pkg::XY_FRAC);
      z_nxt    = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[63]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + arc;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - arc;
      end
      if (step_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  always_comb begin
    z_rnd = z_r + Z_ROUND;
    rnd   = z_rnd[63:hac_pkg::Z_FRAC];
    if (z_r <= 0) k_units = '0;
    else if (rnd > RND_BITS'(hac_pkg::UNITS_45))
      k_units = hac_pkg::FIELD_BITS'(hac_pkg::UNITS_45);
    else k_units = rnd[hac_pkg::FIELD_BITS-1:0];
  end

  assign done = done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hac_div.sv =====
// hac_div: restoring divider, one quotient bit per cycle, ten-bit quotient.
// The caller keeps the quotient below 1024. Depends on hac_pkg.
`default_nettype none

module hac_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [hac_pkg::NUM_BITS-1:0]  num,
  input  wire logic [hac_pkg::DEN_BITS-1:0]  den,
  output logic                               done,
  output logic [hac_pkg::Q_BITS-1:0]         quot
);

  localparam logic [hac_pkg::QIDX_BITS-1:0] BIT_TOP =
    hac_pkg::QIDX_BITS'(hac_pkg::Q_BITS - 1);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [hac_pkg::QIDX_BITS-1:0]  bit_r, bit_nxt;
  logic [hac_pkg::NUM_BITS-1:0]   rem_r, rem_nxt, trial;
  logic [hac_pkg::DEN_BITS-1:0]   den_r, den_nxt;
  logic [hac_pkg::Q_BITS-1:0]     q_r, q_nxt;

  always_comb begin
    trial    = hac_pkg::NUM_BITS'(den_r) << bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      q_nxt    = '0;
      bit_nxt  = BIT_TOP;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt       = rem_r - trial;
        q_nxt[bit_r]  = 1'b1;
      end
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bit_r  <= bit_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hac_lane.sv =====
// hac_lane: one sensor lane: angle from the cordic unit, window hold,
// scaling and running average through a shared divider.
// Depends on hac_pkg, hac_cordic and hac_div.
`default_nettype none

module hac_lane (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]  field_x,
  input  wire logic signed [hac_pkg::FIELD_BITS-1:0]  field_y,
  input  wire hac_pkg::win_t                          win,
  output logic                                        busy,
  output logic [hac_pkg::AXIS_BITS-1:0]               axis
);

  localparam int SUM_BITS  = 14;
  localparam int FILL_BITS = 4;
  localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(hac_pkg::AVG_WINDOW);
  localparam logic [FILL_BITS-1:0] PTR_LAST  = FILL_BITS'(hac_pkg::AVG_WINDOW - 1);

  hac_pkg::lane_state_t state_r, state_nxt;

  logic signed [hac_pkg::ANGLE_BITS-1:0] held_r, held_nxt;
  logic                                  swap_r, swap_nxt, xneg_r, xneg_nxt;
  logic                                  yneg_r, yneg_nxt, zero_r, zero_nxt;
  logic [hac_pkg::AXIS_BITS-1:0]         val_r, val_nxt, axis_r, axis_nxt;
  logic [SUM_BITS-1:0]                   sum_r, sum_nxt, sum_n;
  logic [FILL_BITS-1:0]                  fill_r, fill_nxt, fill_n, ptr_r, ptr_nxt;
  logic [hac_pkg::AXIS_BITS-1:0]         hist_r [hac_pkg::AVG_WINDOW];
  logic                                  hist_we;

  logic [hac_pkg::FIELD_BITS-1:0] ax, ay, s_mag, l_mag, k_units;
  logic                           in_swap;
  logic                           cordic_start, cordic_done;
  logic                           div_start, div_done;
  logic [hac_pkg::NUM_BITS-1:0]   div_num;
  logic [hac_pkg::DEN_BITS-1:0]   div_den;
  logic [hac_pkg::Q_BITS-1:0]     div_q;

  logic [13:0]                           a0;
  logic [hac_pkg::ANGLE_BITS-1:0]        a1;
  logic signed [hac_pkg::ANGLE_BITS-1:0] ang;
  logic                                  in_win;
  logic signed [15:0]                    diff, den_s;
  logic signed [hac_pkg::NUM_BITS-1:0]   diff_w, num_s;
  logic [hac_pkg::NUM_BITS-1:0]          den_sh;

  // fold into the first octant
  always_comb begin
    ax      = field_x[hac_pkg::FIELD_BITS-1] ? unsigned'(-field_x) : unsigned'(field_x);
    ay      = field_y[hac_pkg::FIELD_BITS-1] ? unsigned'(-field_y) : unsigned'(field_y);
    in_swap = ay > ax;
    s_mag   = in_swap ? ax : ay;
    l_mag   = in_swap ? ay : ax;
  end

  hac_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .s_mag   (s_mag),
    .l_mag   (l_mag),
    .done    (cordic_done),
    .k_units (k_units)
  );

  hac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // unfold, window and scale terms
  always_comb begin
    a0 = swap_r ? (14'(hac_pkg::UNITS_90) - 14'(k_units)) : 14'(k_units);
    a1 = xneg_r ? (15'(hac_pkg::UNITS_180) - {1'b0, a0}) : {1'b0, a0};
    if (zero_r) ang = '0;
    else if (yneg_r) ang = -signed'(a1);
    else ang = signed'(a1);
    in_win = (ang >= win.min_angle) && (ang <= win.max_angle);

    diff   = {held_r[hac_pkg::ANGLE_BITS-1], held_r}
           - {win.min_angle[hac_pkg::ANGLE_BITS-1], win.min_angle};
    den_s  = {win.max_angle[hac_pkg::ANGLE_BITS-1], win.max_angle}
           - {win.min_angle[hac_pkg::ANGLE_BITS-1], win.min_angle};
    diff_w = hac_pkg::NUM_BITS'(diff);
    num_s  = (diff_w <<< hac_pkg::AXIS_BITS) - diff_w;
    den_sh = hac_pkg::NUM_BITS'(unsigned'(den_s)) << hac_pkg::AXIS_BITS;

    fill_n = (fill_r == FILL_FULL) ? fill_r : fill_r + 1'b1;
    if (fill_r == FILL_FULL)
      sum_n = sum_r - SUM_BITS'(hist_r[ptr_r]) + SUM_BITS'(val_r);
    else
      sum_n = sum_r + SUM_BITS'(val_r);
  end

  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    swap_nxt     = swap_r;
    xneg_nxt     = xneg_r;
    yneg_nxt     = yneg_r;
    zero_nxt     = zero_r;
    val_nxt      = val_r;
    axis_nxt     = axis_r;
    sum_nxt      = sum_r;
    fill_nxt     = fill_r;
    ptr_nxt      = ptr_r;
    hist_we      = 1'b0;
    cordic_start = 1'b0;
    div_start    = 1'b0;
    div_num      = unsigned'(num_s);
    div_den      = unsigned'(den_s);
    unique case (state_r)
      hac_pkg::LN_IDLE: begin
        if (start) begin
          cordic_start = 1'b1;
          swap_nxt     = in_swap;
          xneg_nxt     = field_x[hac_pkg::FIELD_BITS-1];
          yneg_nxt     = field_y[hac_pkg::FIELD_BITS-1];
          zero_nxt     = (field_x == '0) && (field_y == '0);
          state_nxt    = hac_pkg::LN_ANGLE;
        end
      end
      hac_pkg::LN_ANGLE: begin
        if (cordic_done) begin
          if (in_win) held_nxt = ang;
          state_nxt = hac_pkg::LN_SCALE_SET;
        end
      end
      hac_pkg::LN_SCALE_SET: begin
        if (den_s <= 0 || num_s <= 0) begin
          val_nxt   = '0;
          state_nxt = hac_pkg::LN_AVG_SET;
        end else if (unsigned'(num_s) >= den_sh) begin
          val_nxt   = hac_pkg::AXIS_BITS'(hac_pkg::FULL_SCALE);
          state_nxt = hac_pkg::LN_AVG_SET;
        end else begin
          div_start = 1'b1;
          state_nxt = hac_pkg::LN_SCALE;
        end
      end
      hac_pkg::LN_SCALE: begin
        if (div_done) begin
          val_nxt   = div_q;
          state_nxt = hac_pkg::LN_AVG_SET;
        end
      end
      hac_pkg::LN_AVG_SET: begin
        hist_we   = 1'b1;
        sum_nxt   = sum_n;
        fill_nxt  = fill_n;
        ptr_nxt   = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        div_start = 1'b1;
        div_num   = hac_pkg::NUM_BITS'(sum_n + SUM_BITS'(fill_n >> 1));
        div_den   = hac_pkg::DEN_BITS'(fill_n);
        state_nxt = hac_pkg::LN_AVG;
      end
      hac_pkg::LN_AVG: begin
        if (div_done) begin
          axis_nxt  = div_q;
          state_nxt = hac_pkg::LN_IDLE;
        end
      end
      default: state_nxt = hac_pkg::LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hac_pkg::LN_IDLE;
      held_r  <= hac_pkg::ANGLE_BITS'(hac_pkg::MIN_ANGLE_RESET);
      sum_r   <= '0;
      fill_r  <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      sum_r   <= sum_nxt;
      fill_r  <= fill_nxt;
      ptr_r   <= ptr_nxt;
    end
    swap_r <= swap_nxt;
    xneg_r <= xneg_nxt;
    yneg_r <= yneg_nxt;
    zero_r <= zero_nxt;
    val_r  <= val_nxt;
    axis_r <= axis_nxt;
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_r[ptr_r] <= val_r;
  end

  assign busy = (state_r != hac_pkg::LN_IDLE);
  assign axis = axis_r;

endmodule

`default_nettype wire
